@@ design/tpfs_pkg.sv @@
// Package with the shared types and constants of the timing pattern strobe generator.
`timescale 1ns / 1ps

package tpfs_pkg;

   localparam int MAX_SLOTS       = 8;
   localparam int DATA_WIDTH      = 32;
   localparam int SLOT_WIDTH      = 16;
   localparam int SLOT_IDX_WIDTH  = $clog2(MAX_SLOTS);
   localparam int COUNT_WIDTH     = 4;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int SLOTS_PER_REG   = CSR_DATA_WIDTH / SLOT_WIDTH;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INTERVAL     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_START_OFFSET = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SLOT_COUNT   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SLOTS_LOW    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SLOTS_HIGH   = 3'd4;

   localparam logic [SLOT_WIDTH-1:0]  INTERVAL_RESET     = 16'd10;
   localparam logic [SLOT_WIDTH-1:0]  START_OFFSET_RESET = 16'd0;
   localparam logic [COUNT_WIDTH-1:0] SLOT_COUNT_RESET   = 4'd0;

   typedef struct packed {
      logic                          fifo_has_data;
      logic signed [DATA_WIDTH-1:0]  fifo_head;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0]  signal_value;
      logic                          fifo_pop;
      logic                          underrun;
      logic                          config_error;
   } rsp_type;

endpackage

@@ design/timing_pattern_fifo_to_signal.sv @@
// Top level of the timing pattern strobe generator: pattern check, tick step and result register.
`timescale 1ns / 1ps

// Each request is one tick of the output timing and yields exactly one response in the next
// cycle; a request is taken every cycle while the response register is empty or being
// drained, so the sustained rate is one request per cycle. The pattern check compares all
// eight slots in parallel against the configuration registers, and the tick step (start
// delay, phase wrap, slot match and pop) is one pass of logic between the request port and
// the response register. Writing a known register restarts the pattern and keeps the held value.
module timing_pattern_fifo_to_signal (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  tpfs_pkg::req_type                       req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output tpfs_pkg::rsp_type                       rsp_data,
   input  logic                                    csr_write_en,
   input  logic [tpfs_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [tpfs_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   // Configuration registers.
   logic [tpfs_pkg::SLOT_WIDTH-1:0]     interval_ff;
   logic [tpfs_pkg::SLOT_WIDTH-1:0]     start_offset_ff;
   logic [tpfs_pkg::COUNT_WIDTH-1:0]    slot_count_ff;
   logic [tpfs_pkg::CSR_DATA_WIDTH-1:0] slots_low_ff;
   logic [tpfs_pkg::CSR_DATA_WIDTH-1:0] slots_high_ff;

   // Tick state.
   logic [tpfs_pkg::SLOT_WIDTH-1:0]     offset_left_ff, offset_left_in;
   logic [tpfs_pkg::SLOT_WIDTH-1:0]     phase_ff, phase_in;
   logic [tpfs_pkg::SLOT_IDX_WIDTH-1:0] slot_index_ff, slot_index_in;
   logic [tpfs_pkg::DATA_WIDTH-1:0]     held_value_ff, held_value_in;

   logic                                rsp_valid_ff;
   tpfs_pkg::rsp_type                   rsp_data_ff, rsp_data_in;

   logic [2*tpfs_pkg::CSR_DATA_WIDTH-1:0] slots_all;
   logic [tpfs_pkg::SLOT_WIDTH-1:0]     slot [tpfs_pkg::MAX_SLOTS];
   logic                                pattern_ok;
   logic                                csr_hit;
   logic                                req_fire;
   logic [tpfs_pkg::SLOT_WIDTH-1:0]     restart_offset;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Unpack the slot registers: slot 0 sits in the low bits of the low register.
   assign slots_all = {slots_high_ff, slots_low_ff};

   always_comb begin
      for (int i = 0; i < tpfs_pkg::MAX_SLOTS; i++) begin
         slot[i] = slots_all[i*tpfs_pkg::SLOT_WIDTH +: tpfs_pkg::SLOT_WIDTH];
      end
   end

   // The pattern must be nonempty, fit in the period and rise strictly from slot to slot.
   always_comb begin
      pattern_ok = (slot_count_ff != '0)
                && (slot_count_ff <= tpfs_pkg::COUNT_WIDTH'(tpfs_pkg::MAX_SLOTS))
                && (interval_ff != '0);
      for (int i = 0; i < tpfs_pkg::MAX_SLOTS; i++) begin
         if (tpfs_pkg::COUNT_WIDTH'(i) < slot_count_ff) begin
            if (slot[i] >= interval_ff) begin
               pattern_ok = 1'b0;
            end
            if (i > 0) begin
               if (slot[i] <= slot[(i > 0) ? i-1 : 0]) begin
                  pattern_ok = 1'b0;
               end
            end
         end
      end
   end

   always_comb begin
      case (csr_index)
         tpfs_pkg::REG_INTERVAL,
         tpfs_pkg::REG_START_OFFSET,
         tpfs_pkg::REG_SLOT_COUNT,
         tpfs_pkg::REG_SLOTS_LOW,
         tpfs_pkg::REG_SLOTS_HIGH: begin
            csr_hit = csr_write_en;
         end
         default: begin
            csr_hit = 1'b0;
         end
      endcase
   end

   // A restart picks up a start offset that is written in the same cycle.
   assign restart_offset = (csr_index == tpfs_pkg::REG_START_OFFSET)
                         ? csr_wdata[tpfs_pkg::SLOT_WIDTH-1:0] : start_offset_ff;

   // One tick of the pattern.
   always_comb begin
      logic [tpfs_pkg::SLOT_IDX_WIDTH-1:0] cur_index;
      logic [tpfs_pkg::COUNT_WIDTH-1:0]    index_plus;
      logic [tpfs_pkg::SLOT_WIDTH:0]       phase_plus;

      offset_left_in = offset_left_ff;
      phase_in       = phase_ff;
      slot_index_in  = slot_index_ff;
      held_value_in  = held_value_ff;
      rsp_data_in.fifo_pop     = 1'b0;
      rsp_data_in.underrun     = 1'b0;
      rsp_data_in.config_error = !pattern_ok;

      cur_index  = ({1'b0, slot_index_ff} >= slot_count_ff) ? '0 : slot_index_ff;
      index_plus = {1'b0, cur_index} + tpfs_pkg::COUNT_WIDTH'(1);
      phase_plus = {1'b0, phase_ff} + (tpfs_pkg::SLOT_WIDTH+1)'(1);

      if (pattern_ok) begin
         if (offset_left_ff != '0) begin
            offset_left_in = offset_left_ff - tpfs_pkg::SLOT_WIDTH'(1);
         end else begin
            slot_index_in = cur_index;
            if (phase_ff == slot[cur_index]) begin
               if (req_data.fifo_has_data) begin
                  held_value_in        = req_data.fifo_head;
                  rsp_data_in.fifo_pop = 1'b1;
               end else begin
                  rsp_data_in.underrun = 1'b1;
               end
               slot_index_in = (index_plus >= slot_count_ff)
                             ? '0 : index_plus[tpfs_pkg::SLOT_IDX_WIDTH-1:0];
            end
            phase_in = (phase_plus == {1'b0, interval_ff})
                     ? '0 : phase_plus[tpfs_pkg::SLOT_WIDTH-1:0];
         end
      end
      rsp_data_in.signal_value = held_value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff     <= tpfs_pkg::INTERVAL_RESET;
         start_offset_ff <= tpfs_pkg::START_OFFSET_RESET;
         slot_count_ff   <= tpfs_pkg::SLOT_COUNT_RESET;
         slots_low_ff    <= '0;
         slots_high_ff   <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            tpfs_pkg::REG_INTERVAL: begin
               interval_ff <= csr_wdata[tpfs_pkg::SLOT_WIDTH-1:0];
            end
            tpfs_pkg::REG_START_OFFSET: begin
               start_offset_ff <= csr_wdata[tpfs_pkg::SLOT_WIDTH-1:0];
            end
            tpfs_pkg::REG_SLOT_COUNT: begin
               slot_count_ff <= csr_wdata[tpfs_pkg::COUNT_WIDTH-1:0];
            end
            tpfs_pkg::REG_SLOTS_LOW: begin
               slots_low_ff <= csr_wdata;
            end
            tpfs_pkg::REG_SLOTS_HIGH: begin
               slots_high_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_left_ff <= tpfs_pkg::START_OFFSET_RESET;
         phase_ff       <= '0;
         slot_index_ff  <= '0;
         held_value_ff  <= '0;
      end else if (csr_hit) begin
         offset_left_ff <= restart_offset;
         phase_ff       <= '0;
         slot_index_ff  <= '0;
      end else if (req_fire) begin
         offset_left_ff <= offset_left_in;
         phase_ff       <= phase_in;
         slot_index_ff  <= slot_index_in;
         held_value_ff  <= held_value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Every accepted request leaves a response in the register.
   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid)
      else $error("accepted request produced no response");

   // A stalled response blocks new requests.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request accepted while response stalled");

   // Pop and underrun exclude each other and both vanish on a bad pattern.
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.fifo_pop && rsp_data.underrun)
                 && !(rsp_data.config_error && (rsp_data.fifo_pop || rsp_data.underrun)))
      else $error("inconsistent response flags");

   // A pop only happens when the FIFO reported data.
   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (!rsp_data.fifo_pop || $past(req_data.fifo_has_data)))
      else $error("pop from an empty FIFO");

endmodule
